/* sv/page_frame_free_list_allocator_macros.svh */
// Assertion macros used by the allocator controller
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define PFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pfa_pkg.sv */
package pfa_pkg;

   localparam int PAGE_SHIFT     = 12;
   localparam int RESERVED_SLOTS = 16;
   localparam int REGION_SLOTS   = 16;
   localparam int STACK_DEPTH    = 4096;

   localparam int RES_IDX_W = (RESERVED_SLOTS > 1) ? $clog2(RESERVED_SLOTS) : 1;
   localparam int REG_IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int RES_CNT_W = $clog2(RESERVED_SLOTS + 1);
   localparam int REG_CNT_W = $clog2(REGION_SLOTS + 1);
   localparam int STK_IDX_W = $clog2(STACK_DEPTH);
   localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int PFN_W     = 64 - PAGE_SHIFT;
   localparam int CNT_W     = 13;

   localparam logic [63:0] PG_MASK  = (64'd1 << PAGE_SHIFT) - 64'd1;
   localparam logic [63:0] PG_SIZE  = 64'd1 << PAGE_SHIFT;
   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      OP_ADD_RES = 3'd0,
      OP_ADD_MEM = 3'd1,
      OP_BUILD   = 3'd2,
      OP_ALLOC   = 3'd3,
      OP_FREE    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_PAGES   = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_REJECTED   = 3'd3,
      ST_WRAPS      = 3'd4,
      ST_BAD_KERNEL = 3'd5,
      ST_STACK_FULL = 3'd6
   } status_type;

   localparam logic [1:0] CSR_KSTART = 2'd0;
   localparam logic [1:0] CSR_KEND   = 2'd1;
   localparam logic [1:0] CSR_BSTART = 2'd2;
   localparam logic [1:0] CSR_BSIZE  = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] region_base;
      logic [63:0] region_size;
      logic [63:0] freed_address;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [63:0]      page_address;
      logic [CNT_W-1:0] free_count;
      logic [CNT_W-1:0] total_count;
   } rsp_type;

   // Datapath commands from the controller
   typedef struct packed {
      logic           latch_req;   // capture request payload
      logic           add_res;
      logic           add_mem;
      logic           build_init;  // clear counts, fw start = kstart
      logic           fw_load;     // read region at idx for firmware search
      logic           fw_check;    // compare loaded region
      logic           reg_load;    // load region idx into walk registers
      logic           pg_check;    // evaluate current page
      logic           push_page;   // push current page
      logic           res_load;    // read reserved entry
      logic           res_check;   // compare reserved entry
      logic           pop_req;     // issue stack read
      logic           free_push;
      logic           idx_clear;
      logic           idx_inc;
      logic           ridx_clear;
      logic           ridx_inc;
      logic           adv_page;
      logic           jump_page;
   } cmd_type;

   typedef struct packed {
      op_type operation;
      logic   res_full;
      logic   reg_full;
      logic   kernel_bad;
      logic   idx_end;       // idx == regions_used
      logic   ridx_end;      // ridx == reserved_used
      logic   fw_hit;
      logic   reg_wraps;
      logic   page_done;     // p >= end
      logic   fixed_block;   // kernel / blob / firmware prefix overlap
      logic   res_block;     // loaded reserved entry overlaps
      logic   stack_full;
      logic   stack_empty;
      logic   any_pushed;
      logic   free_bad;
   } stat_type;

endpackage

/* sv/pfa_ctrl.sv */
module pfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pfa_pkg::stat_type stat,
   output pfa_pkg::cmd_type  cmd,
   output logic [2:0]        status,
   output logic              alloc_out
);
   import pfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FW_LOAD, S_FW_CHECK, S_REG_LOAD, S_REG_CHECK,
      S_PAGE, S_SETTLE, S_RES_LOAD, S_RES_CHECK, S_RES_JUMP, S_POP, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;
   logic       dropped_ff, dropped_in;
   logic       alloc_ff, alloc_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign status    = status_ff;
   assign alloc_out = alloc_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      dropped_in   = dropped_ff;
      alloc_in     = alloc_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            alloc_in  = 1'b0;
            state_in  = S_DONE;
            case (stat.operation)
               OP_ADD_RES: begin
                  if (stat.res_full) status_in = ST_TABLE_FULL;
                  else cmd.add_res = 1'b1;
               end
               OP_ADD_MEM: begin
                  if (stat.reg_full) status_in = ST_TABLE_FULL;
                  else cmd.add_mem = 1'b1;
               end
               OP_BUILD: begin
                  if (stat.kernel_bad) status_in = ST_BAD_KERNEL;
                  else begin
                     cmd.build_init = 1'b1;
                     cmd.idx_clear  = 1'b1;
                     dropped_in     = 1'b0;
                     state_in       = S_FW_LOAD;
                  end
               end
               OP_ALLOC: begin
                  if (stat.stack_empty) status_in = ST_NO_PAGES;
                  else begin
                     cmd.pop_req = 1'b1;
                     alloc_in    = 1'b1;
                     state_in    = S_POP;
                  end
               end
               OP_FREE: begin
                  if (stat.free_bad) status_in = ST_REJECTED;
                  else if (stat.stack_full) status_in = ST_STACK_FULL;
                  else cmd.free_push = 1'b1;
               end
               default: ;
            endcase
         end
         S_FW_LOAD: begin
            if (stat.idx_end) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_REG_LOAD;
            end else begin
               cmd.fw_load = 1'b1;
               state_in    = S_FW_CHECK;
            end
         end
         S_FW_CHECK: begin
            cmd.fw_check = 1'b1;
            if (stat.fw_hit) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_REG_LOAD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FW_LOAD;
            end
         end
         S_REG_LOAD: begin
            if (stat.idx_end) begin
               status_in = dropped_ff ? ST_STACK_FULL :
                           (stat.any_pushed ? ST_OK : ST_NO_PAGES);
               state_in  = S_DONE;
            end else begin
               cmd.reg_load = 1'b1;
               state_in     = S_REG_CHECK;
            end
         end
         S_REG_CHECK: begin
            if (stat.reg_wraps) begin
               status_in = ST_WRAPS;
               state_in  = S_DONE;
            end else if (dropped_ff) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_REG_LOAD;
            end else begin
               state_in = S_PAGE;
            end
         end
         S_PAGE: begin
            cmd.pg_check = 1'b1;
            if (stat.page_done) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_REG_LOAD;
            end else if (stat.fixed_block) begin
               cmd.jump_page = 1'b1;
               state_in      = S_SETTLE;
            end else begin
               cmd.ridx_clear = 1'b1;
               state_in       = S_RES_LOAD;
            end
         end
         // skip target is registered from the page, so it lags a page move
         S_SETTLE: state_in = S_PAGE;
         S_RES_LOAD: begin
            if (stat.ridx_end) begin
               if (stat.stack_full) begin
                  dropped_in  = 1'b1;
                  cmd.idx_inc = 1'b1;
                  state_in    = S_REG_LOAD;
               end else begin
                  cmd.push_page = 1'b1;
                  cmd.adv_page  = 1'b1;
                  state_in      = S_SETTLE;
               end
            end else begin
               cmd.res_load = 1'b1;
               state_in     = S_RES_CHECK;
            end
         end
         S_RES_CHECK: begin
            cmd.res_check = 1'b1;
            if (stat.res_block) begin
               state_in = S_RES_JUMP;
            end else begin
               cmd.ridx_inc = 1'b1;
               state_in     = S_RES_LOAD;
            end
         end
         S_RES_JUMP: begin
            cmd.jump_page = 1'b1;
            state_in      = S_SETTLE;
         end
         S_POP: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff) rsp_valid_in = 1'b1;
            else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
         dropped_ff   <= 1'b0;
         alloc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         dropped_ff   <= dropped_in;
         alloc_ff     <= alloc_in;
      end
   end

`include "page_frame_free_list_allocator_macros.svh"
   `PFA_ASSERT_IMP(a_rsp_only_done, clock, reset, rsp_valid_ff, state_ff == S_DONE, "rsp outside done")
   `PFA_ASSERT_IMP(a_no_push_full, clock, reset, cmd.push_page || cmd.free_push, !stat.stack_full, "push on full stack")
   `PFA_ASSERT_IMP(a_no_pop_empty, clock, reset, cmd.pop_req, !stat.stack_empty, "pop on empty stack")
endmodule

/* sv/pfa_dp.sv */
module pfa_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  pfa_pkg::req_type          req,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [63:0]               csr_write_data,
   input  pfa_pkg::cmd_type          cmd,
   output pfa_pkg::stat_type         stat,
   output logic [63:0]               pop_address,
   output logic [pfa_pkg::CNT_W-1:0] free_count,
   output logic [pfa_pkg::CNT_W-1:0] total_count
);
   import pfa_pkg::*;

   logic [63:0] kstart_ff, kend_ff, bstart_ff, bsize_ff;
   req_type     req_ff;
   logic [63:0] res_base_mem [RESERVED_SLOTS];
   logic [63:0] res_size_mem [RESERVED_SLOTS];
   logic [63:0] reg_base_mem [REGION_SLOTS];
   logic [63:0] reg_size_mem [REGION_SLOTS];
   logic [PFN_W-1:0] stack_mem [STACK_DEPTH];
   logic [RES_CNT_W-1:0] res_used_ff;
   logic [REG_CNT_W-1:0] reg_used_ff;
   logic [STK_CNT_W-1:0] fill_ff, fill_in;
   logic [STK_CNT_W-1:0] built_ff;
   logic [REG_CNT_W-1:0] idx_ff;
   logic [RES_CNT_W-1:0] ridx_ff;
   logic [63:0] rb_ff, rs_ff;   // region read data
   logic [63:0] qb_ff, qs_ff;   // reserved read data
   logic [63:0] fw_ff, p_ff, end_ff, jump_ff;
   logic        wraps_ff;
   logic [PFN_W-1:0] pop_ff;
   logic [64:0] rsum;
   logic [63:0] pe, blob_end, res_end;
   logic        blob_hit, kern_hit, fw_hit_pre;

   function automatic logic [63:0] round_up(input logic [63:0] v);
      logic [64:0] t;
      t = {1'b0, v} + {1'b0, PG_MASK};
      if (t[64]) return ALL_ONES & ~PG_MASK;
      return t[63:0] & ~PG_MASK;
   endfunction

   function automatic logic [63:0] sat_end(input logic [63:0] b, input logic [63:0] s);
      logic [64:0] t;
      t = {1'b0, b} + {1'b0, s};
      return t[64] ? ALL_ONES : t[63:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         kstart_ff <= '0;
         kend_ff   <= '0;
         bstart_ff <= '0;
         bsize_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KSTART: kstart_ff <= csr_write_data;
            CSR_KEND:   kend_ff   <= csr_write_data;
            CSR_BSTART: bstart_ff <= csr_write_data;
            CSR_BSIZE:  bsize_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // table and stack storage
   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req;
      if (cmd.add_res) begin
         res_base_mem[res_used_ff[RES_IDX_W-1:0]] <= req_ff.region_base;
         res_size_mem[res_used_ff[RES_IDX_W-1:0]] <= req_ff.region_size;
      end
      if (cmd.add_mem) begin
         reg_base_mem[reg_used_ff[REG_IDX_W-1:0]] <= req_ff.region_base;
         reg_size_mem[reg_used_ff[REG_IDX_W-1:0]] <= req_ff.region_size;
      end
      if (cmd.fw_load || cmd.reg_load) begin
         rb_ff <= reg_base_mem[idx_ff[REG_IDX_W-1:0]];
         rs_ff <= reg_size_mem[idx_ff[REG_IDX_W-1:0]];
      end
      if (cmd.res_load) begin
         qb_ff <= res_base_mem[ridx_ff[RES_IDX_W-1:0]];
         qs_ff <= res_size_mem[ridx_ff[RES_IDX_W-1:0]];
      end
      if (cmd.push_page)
         stack_mem[fill_ff[STK_IDX_W-1:0]] <= p_ff[63:PAGE_SHIFT];
      else if (cmd.free_push)
         stack_mem[fill_ff[STK_IDX_W-1:0]] <= req_ff.freed_address[63:PAGE_SHIFT];
      if (cmd.pop_req) pop_ff <= stack_mem[fill_in[STK_IDX_W-1:0]];
   end

   assign rsum = {1'b0, rb_ff} + {1'b0, rs_ff};

   // walk registers: region end is registered from the region read data loaded by reg_load
   always_ff @(posedge clock) begin
      if (cmd.build_init) fw_ff <= kstart_ff;
      else if (cmd.fw_check && fw_hit_pre) fw_ff <= rb_ff;
      if (cmd.reg_load) begin
         p_ff     <= round_up(reg_base_mem[idx_ff[REG_IDX_W-1:0]]);
         wraps_ff <= 1'b0;
      end else if (cmd.adv_page) p_ff <= p_ff + PG_SIZE;
      else if (cmd.jump_page) p_ff <= jump_ff;
      end_ff <= rsum[63:0] & ~PG_MASK;
      if (kern_hit) jump_ff <= round_up(kend_ff);
      else if (blob_hit) jump_ff <= round_up(blob_end);
      else if (cmd.res_check) jump_ff <= round_up(res_end);
      else jump_ff <= round_up(kstart_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_used_ff <= '0;
         reg_used_ff <= '0;
         fill_ff     <= '0;
         built_ff    <= '0;
         idx_ff      <= '0;
         ridx_ff     <= '0;
      end else begin
         if (cmd.add_res) res_used_ff <= res_used_ff + 1'b1;
         if (cmd.add_mem) reg_used_ff <= reg_used_ff + 1'b1;
         fill_ff <= fill_in;
         if (cmd.build_init) built_ff <= '0;
         else if (cmd.push_page) built_ff <= built_ff + 1'b1;
         if (cmd.idx_clear) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
         if (cmd.ridx_clear) ridx_ff <= '0;
         else if (cmd.ridx_inc) ridx_ff <= ridx_ff + 1'b1;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.build_init) fill_in = '0;
      else if (cmd.push_page || cmd.free_push) fill_in = fill_ff + 1'b1;
      else if (cmd.pop_req) fill_in = fill_ff - 1'b1;
   end

   // page overlap tests; jump_ff picks the matching skip target each cycle
   assign pe       = p_ff + PG_SIZE;
   assign blob_end = sat_end(bstart_ff, bsize_ff);
   assign res_end  = sat_end(qb_ff, qs_ff);
   assign kern_hit = (p_ff < kend_ff) && (kstart_ff < pe);
   assign blob_hit = (bsize_ff != '0) && (p_ff < blob_end) && (bstart_ff < pe);
   assign fw_hit_pre = (kstart_ff >= rb_ff) && (kstart_ff < rsum[63:0]);

   always_comb begin
      stat             = '0;
      stat.operation   = op_type'(req_ff.operation);
      stat.res_full    = (res_used_ff >= RES_CNT_W'(RESERVED_SLOTS));
      stat.reg_full    = (reg_used_ff >= REG_CNT_W'(REGION_SLOTS));
      stat.kernel_bad  = (kstart_ff >= kend_ff);
      stat.idx_end     = (idx_ff == reg_used_ff);
      stat.ridx_end    = (ridx_ff == res_used_ff);
      stat.fw_hit      = fw_hit_pre;
      stat.reg_wraps   = rsum[64];
      stat.page_done   = !(p_ff < end_ff);
      stat.fixed_block = kern_hit || blob_hit || ((p_ff >= fw_ff) && (p_ff < kstart_ff));
      stat.res_block   = (qs_ff != '0) && (p_ff < res_end) && (qb_ff < pe);
      stat.stack_full  = (fill_ff >= STK_CNT_W'(STACK_DEPTH));
      stat.stack_empty = (fill_ff == '0);
      stat.any_pushed  = (fill_ff != '0);
      stat.free_bad    = ((req_ff.freed_address & PG_MASK) != '0) || (req_ff.freed_address == '0);
   end

   assign pop_address = {pop_ff, {PAGE_SHIFT{1'b0}}};
   assign free_count  = CNT_W'(fill_ff);
   assign total_count = CNT_W'(built_ff);
endmodule

/* sv/page_frame_free_list_allocator.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  operation, region, freed address
// rsp       out        rsp_valid/rsp_ready  status, page address, counts
// csr       in         csr_write_enable     kernel and blob registers
// Add and free go from decode straight to the response state; alloc passes a pop state.
// Build: a firmware search loads and checks each region in turn, then the walk loads each
// region, checks each page for overlap and against the reserved entries, and pushes or skips it.
// No clearing pass after reset; reset is synchronous. One item at a time.
// A stalled rsp holds the block until the item is taken.
module page_frame_free_list_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfa_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_write_data
);
   import pfa_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   logic [2:0]        status;
   logic              alloc_out;
   logic [63:0]       pop_address;
   logic [CNT_W-1:0]  free_count, total_count;

   pfa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd, .status, .alloc_out
   );

   pfa_dp u_dp (
      .clock, .reset, .req(req_data), .csr_write_enable, .csr_index,
      .csr_write_data, .cmd, .stat, .pop_address, .free_count, .total_count
   );

   assign rsp_data.status       = status;
   assign rsp_data.page_address = alloc_out ? pop_address : 64'd0;
   assign rsp_data.free_count   = free_count;
   assign rsp_data.total_count  = total_count;
endmodule

/* tb/testbench.sv */
module testbench;
   import pfa_pkg::*;

   localparam int          WATCHDOG_LIMIT = 600000;
   localparam int          MAX_GAP        = 11;
   localparam int          SETTLE_CYCLES  = 20;
   localparam logic [2:0]  OP_SPARE_LO    = 3'd5;
   localparam logic [2:0]  OP_SPARE_HI    = 3'd7;
   localparam logic [63:0] SMALL_AREA     = 64'h8000_0000;
   localparam logic [63:0] BIG_BASE       = 64'h1_0000_0000;
   localparam logic [63:0] BIG_BYTES      = 64'd5000 << PAGE_SHIFT;
   localparam logic [63:0] BLOB_BYTES     = 64'h200_0000;
   localparam logic [63:0] TOP_PAGE       = ALL_ONES & ~PG_MASK;

   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [63:0] val;
      req_type     r;
      bit          typed;
      rsp_type     e;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   page_frame_free_list_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // allocator state as predicted
   logic [63:0]      k_start, k_end, b_start, b_size, fw_base;
   logic [63:0]      res_base [RESERVED_SLOTS];
   logic [63:0]      res_len  [RESERVED_SLOTS];
   logic [63:0]      mem_base [REGION_SLOTS];
   logic [63:0]      mem_len  [REGION_SLOTS];
   int               res_used, mem_used, fill, built;
   logic [PFN_W-1:0] pstack [STACK_DEPTH];

   rsp_type     awaited_rsp[$];
   logic [63:0] handed_out[$];
   bit          typed_has;
   rsp_type     typed_rsp;
   int          idle_max, hold_off;
   int          items_sent, results_seen, builds_sent, errors, idle_cycles;
   row_type     dir_rows[$];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] page_ceil(logic [63:0] v);
      if (v > ALL_ONES - PG_MASK)
         return TOP_PAGE;
      return (v + PG_MASK) & ~PG_MASK;
   endfunction

   function automatic logic [63:0] clip_end(logic [63:0] b, logic [63:0] s);
      return (b > ALL_ONES - s) ? ALL_ONES : b + s;
   endfunction

   // returns p when the page is usable, else the first page past the blocker
   function automatic logic [63:0] first_clear(logic [63:0] p);
      logic [63:0] pe, oe;
      pe = p + PG_SIZE;
      if (p < k_end && k_start < pe)
         return page_ceil(k_end);
      if (b_size != 0) begin
         oe = clip_end(b_start, b_size);
         if (p < oe && b_start < pe)
            return page_ceil(oe);
      end
      if (p >= fw_base && p < k_start)
         return page_ceil(k_start);
      for (int i = 0; i < res_used; i++) begin
         if (res_len[i] != 0) begin
            oe = clip_end(res_base[i], res_len[i]);
            if (p < oe && res_base[i] < pe)
               return page_ceil(oe);
         end
      end
      return p;
   endfunction

   function automatic status_type build_stack();
      logic [63:0] raw_end, p, pend, q;
      bit          dropped;
      dropped = 1'b0;
      if (k_start >= k_end)
         return ST_BAD_KERNEL;
      fill    = 0;
      built   = 0;
      fw_base = k_start;
      for (int i = 0; i < mem_used; i++) begin
         raw_end = mem_base[i] + mem_len[i];
         if (k_start >= mem_base[i] && k_start < raw_end) begin
            fw_base = mem_base[i];
            break;
         end
      end
      for (int i = 0; i < mem_used; i++) begin
         raw_end = mem_base[i] + mem_len[i];
         p       = page_ceil(mem_base[i]);
         pend    = raw_end & ~PG_MASK;
         if (raw_end < mem_base[i])
            return ST_WRAPS;
         // after a drop only the wrap check of later regions remains
         if (!dropped) begin
            while (p < pend) begin
               q = first_clear(p);
               if (q != p) begin
                  p = q;
               end else if (fill >= STACK_DEPTH) begin
                  dropped = 1'b1;
                  break;
               end else begin
                  pstack[fill] = p[63:PAGE_SHIFT];
                  fill++;
                  built++;
                  p += PG_SIZE;
               end
            end
         end
      end
      if (dropped)
         return ST_STACK_FULL;
      return (fill == 0) ? ST_NO_PAGES : ST_OK;
   endfunction

   function automatic rsp_type next_response(req_type r);
      rsp_type o;
      o = '0;
      case (r.operation)
         OP_ADD_RES: begin
            if (res_used >= RESERVED_SLOTS) begin
               o.status = ST_TABLE_FULL;
            end else begin
               res_base[res_used] = r.region_base;
               res_len[res_used]  = r.region_size;
               res_used++;
            end
         end
         OP_ADD_MEM: begin
            if (mem_used >= REGION_SLOTS) begin
               o.status = ST_TABLE_FULL;
            end else begin
               mem_base[mem_used] = r.region_base;
               mem_len[mem_used]  = r.region_size;
               mem_used++;
            end
         end
         OP_BUILD: o.status = build_stack();
         OP_ALLOC: begin
            if (fill == 0) begin
               o.status = ST_NO_PAGES;
            end else begin
               fill--;
               o.page_address = {pstack[fill], PAGE_SHIFT'(0)};
            end
         end
         OP_FREE: begin
            if ((r.freed_address & PG_MASK) != 0 || r.freed_address == 0) begin
               o.status = ST_REJECTED;
            end else if (fill >= STACK_DEPTH) begin
               o.status = ST_STACK_FULL;
            end else begin
               pstack[fill] = r.freed_address[63:PAGE_SHIFT];
               fill++;
            end
         end
         default: ;
      endcase
      o.free_count  = CNT_W'(fill);
      o.total_count = CNT_W'(built);
      return o;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      pick, sub;
      r.operation     = OP_ALLOC;
      r.region_base   = {$urandom, $urandom};
      r.region_size   = {$urandom, $urandom};
      r.freed_address = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
         r.operation = OP_ALLOC;
      end else if (pick < 70) begin
         r.operation = OP_FREE;
         sub = $urandom_range(0, 9);
         if (sub < 6 && handed_out.size() > 0)
            r.freed_address = handed_out[$urandom_range(0, handed_out.size() - 1)];
         else if (sub == 6)
            r.freed_address = '0;
         else if (sub >= 8)
            r.freed_address &= ~PG_MASK;
      end else if (pick < 74) begin
         r.operation = OP_BUILD;
      end else if (pick < 85) begin
         r.operation = OP_ADD_RES;
         if (res_used < RESERVED_SLOTS && $urandom_range(0, 4) != 0) begin
            r.region_base = SMALL_AREA + (64'($urandom_range(0, 63)) << PAGE_SHIFT)
                            + 64'($urandom_range(0, 1) * $urandom_range(0, 4095));
            r.region_size = (64'($urandom_range(0, 3)) << PAGE_SHIFT)
                            + 64'($urandom_range(0, 4095));
            if ($urandom_range(0, 7) == 0)
               r.region_size = '0;
         end
      end else if (pick < 95) begin
         if (mem_used < REGION_SLOTS - 2) begin
            r.operation   = OP_ADD_MEM;
            r.region_base = SMALL_AREA + (64'($urandom_range(0, 63)) << PAGE_SHIFT)
                            + 64'($urandom_range(0, 1) * $urandom_range(0, 4095));
            r.region_size = (64'($urandom_range(0, 8)) << PAGE_SHIFT)
                            + 64'($urandom_range(0, 4095));
         end else if (mem_used >= REGION_SLOTS) begin
            r.operation = OP_ADD_MEM;
         end
      end else begin
         r.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return r;
   endfunction

   task automatic send(req_type r, bit has, rsp_type e);
      int gap;
      bit taken;
      gap       = $urandom_range(0, idle_max);
      typed_has = has;
      typed_rsp = e;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
         taken = req_ready;
         @(negedge clock);
      end while (!taken);
      items_sent++;
      if (r.operation == OP_BUILD)
         builds_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         CSR_KSTART: k_start = val;
         CSR_KEND:   k_end   = val;
         CSR_BSTART: b_start = val;
         default:    b_size  = val;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [63:0] ks, logic [63:0] ke,
                             logic [63:0] bs, logic [63:0] bz);
      drain();
      write_reg(CSR_KSTART, ks);
      write_reg(CSR_KEND, ke);
      write_reg(CSR_BSTART, bs);
      write_reg(CSR_BSIZE, bz);
   endtask

   task automatic random_run(int count);
      for (int n = 0; n < count; n++)
         send(random_item(), 1'b0, '0);
   endtask

   // result check and input acceptance
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         results_seen++;
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t: result with none awaited: st=%0d addr=%h free=%0d total=%0d",
                     $time, got.status, got.page_address, got.free_count,
                     got.total_count);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status != want.status || got.page_address != want.page_address ||
                got.free_count != want.free_count || got.total_count != want.total_count)
            begin
               errors++;
               if (errors < 40)
                  $display("%0t: mismatch exp st=%0d addr=%h free=%0d total=%0d, got st=%0d addr=%h free=%0d total=%0d",
                           $time, want.status, want.page_address, want.free_count,
                           want.total_count, got.status, got.page_address,
                           got.free_count, got.total_count);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         want = next_response(req_data);
         if (req_data.operation == OP_ALLOC && want.status == ST_OK) begin
            handed_out.push_back(want.page_address);
            if (handed_out.size() > 64)
               void'(handed_out.pop_front());
         end
         awaited_rsp.push_back(typed_has ? typed_rsp : want);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int gap;
      bit taken;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = (hold_off > 0) ? hold_off : $urandom_range(0, idle_max);
         hold_off = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
            taken = rsp_valid;
            @(negedge clock);
         end while (!taken);
      end
   end

   initial begin
      row_type row;
      req_type r;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_KSTART;
      csr_write_data   = '0;
      k_start = '0; k_end = '0; b_start = '0; b_size = '0; fw_base = '0;
      res_used = 0; mem_used = 0; fill = 0; built = 0;
      idle_max = MAX_GAP; hold_off = 0;
      items_sent = 0; results_seen = 0; builds_sent = 0; errors = 0; idle_cycles = 0;
      typed_has = 1'b0; typed_rsp = '0;

      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ALLOC, 0, 0, 0}, 1, '{ST_NO_PAGES, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_FREE, 0, 0, 0}, 1, '{ST_REJECTED, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_FREE, 0, 0, 64'h8000_0123}, 1,
                           '{ST_REJECTED, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_FREE, 0, 0, TOP_PAGE}, 1, '{ST_OK, 0, 1, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ALLOC, 0, 0, 0}, 1, '{ST_OK, TOP_PAGE, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_BUILD, 0, 0, 0}, 1, '{ST_BAD_KERNEL, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_SPARE_LO, ALL_ONES, ALL_ONES, ALL_ONES}, 1,
                           '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_SPARE_HI, 0, 0, 0}, 1, '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_MEM, BIG_BASE, BIG_BYTES, 0}, 1,
                           '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_MEM, SMALL_AREA, 64'h4000, 0}, 1,
                           '{ST_OK, 0, 0, 0}});
      // aligning this base up saturates to the top page
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_MEM, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 0},
                           1, '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_MEM, 64'hFFFF_FFFF_FFFF_E001, 64'h1FFE, 0},
                           1, '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_RES, SMALL_AREA + 64'h1800, 0, 0}, 1,
                           '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_RES, SMALL_AREA + 64'h2800, 64'h10, 0}, 1,
                           '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ADD_RES, 64'hFFFF_FFFF_FFFF_0000, ALL_ONES, 0},
                           1, '{ST_OK, 0, 0, 0}});
      dir_rows.push_back('{1, CSR_BSTART, BIG_BASE, '0, 0, '0});
      dir_rows.push_back('{1, CSR_BSIZE, BLOB_BYTES, '0, 0, '0});
      dir_rows.push_back('{1, CSR_KSTART, SMALL_AREA + 64'h3000, '0, 0, '0});
      dir_rows.push_back('{1, CSR_KEND, SMALL_AREA + 64'h3001, '0, 0, '0});
      // firmware prefix and kernel swallow the small region, blob covers the big one
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_BUILD, 0, 0, 0}, 1, '{ST_NO_PAGES, 0, 0, 0}});
      dir_rows.push_back('{1, CSR_KSTART, 64'h4000_0000, '0, 0, '0});
      dir_rows.push_back('{1, CSR_KEND, 64'h4000_1000, '0, 0, '0});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_BUILD, 0, 0, 0}, 0, '0});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_ALLOC, 0, 0, 0}, 0, '0});
      dir_rows.push_back('{0, CSR_KSTART, 0, '{OP_FREE, 0, 0, SMALL_AREA + 64'h1000}, 0, '0});

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            drain();
            write_reg(row.idx, row.val);
         end else begin
            send(row.r, row.typed, row.e);
         end
      end

      set_config(SMALL_AREA + 64'h2_0000, SMALL_AREA + 64'h2_2000, BIG_BASE, BLOB_BYTES);
      random_run(600);

      set_config(SMALL_AREA + 64'h3_F000, SMALL_AREA + 64'h40_0000, BIG_BASE, BLOB_BYTES);
      idle_max = 0;
      random_run(150);
      idle_max = MAX_GAP;

      // long result stall: the block holds its result and backs up its input
      drain();
      idle_max = 2;
      hold_off = 300;
      random_run(40);
      idle_max = MAX_GAP;

      // big region exposed: build overflows the stack, then frees hit a full stack
      set_config(64'h4000_0000, 64'h4000_1000, BIG_BASE, '0);
      r = '0;
      r.operation = OP_BUILD;
      send(r, 1'b0, '0);
      r.operation = OP_FREE;
      r.freed_address = 64'h5000_0000;
      send(r, 1'b0, '0);
      send(r, 1'b0, '0);
      r.operation = OP_ALLOC;
      send(r, 1'b0, '0);
      send(r, 1'b0, '0);

      set_config('0, ALL_ONES, ALL_ONES, ALL_ONES);
      random_run(100);
      set_config(ALL_ONES, '0, BIG_BASE, BLOB_BYTES);
      random_run(50);

      // fill the region table, the last entry running to the top of the space
      set_config(SMALL_AREA + 64'h1_0000, SMALL_AREA + 64'h1_4000, BIG_BASE, ALL_ONES);
      r = '0;
      r.operation = OP_ADD_MEM;
      while (mem_used < REGION_SLOTS - 1) begin
         r.region_base = SMALL_AREA + (64'($urandom_range(0, 63)) << PAGE_SHIFT);
         r.region_size = 64'($urandom_range(1, 6)) << PAGE_SHIFT;
         send(r, 1'b0, '0);
      end
      r.region_base = TOP_PAGE;
      r.region_size = PG_SIZE;
      send(r, 1'b0, '0);
      random_run(600);

      drain();
      $display("%0d items sent (%0d builds), %0d results checked, %0d mismatches",
               items_sent, builds_sent, results_seen, errors);
      $display("covered directed corners, random traffic, stack overflow and table wrap");
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
